// ----- rtl/http_response_header_parser_unit_macros.svh -----
// Assertion macros shared by the response parser RTL.
// No dependencies; include by bare file name.
`ifndef HTTP_RESPONSE_HEADER_PARSER_UNIT_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HRHP_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("hrhp: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define HRHP_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("hrhp: next-cycle check failed");

`endif

// ----- rtl/hrhp_pkg.sv -----
// Types and fixed constants of the HTTP response header parser.
// No dependencies.
package hrhp_pkg;

   localparam int BYTE_W = 8;
   localparam int CAP_W  = 17;
   localparam int MAG_W  = 16;
   localparam int CODE_W = 17;
   localparam int LEN_W  = 16;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [1:0]        phase_type;

   localparam byte_type CHAR_NUL   = 8'h00;
   localparam byte_type CHAR_TAB   = 8'h09;
   localparam byte_type CHAR_LF    = 8'h0A;
   localparam byte_type CHAR_VT    = 8'h0B;
   localparam byte_type CHAR_FF    = 8'h0C;
   localparam byte_type CHAR_CR    = 8'h0D;
   localparam byte_type CHAR_SPACE = 8'h20;
   localparam byte_type CHAR_PLUS  = 8'h2B;
   localparam byte_type CHAR_MINUS = 8'h2D;
   localparam byte_type CHAR_ZERO  = 8'h30;
   localparam byte_type CHAR_NINE  = 8'h39;

   // number parser phases
   localparam phase_type PH_SKIP   = 2'd0;
   localparam phase_type PH_SIGN   = 2'd1;
   localparam phase_type PH_DIGITS = 2'd2;
   localparam phase_type PH_DONE   = 2'd3;

   localparam logic [CAP_W-1:0] CAP_RESET = 17'd1500;
   localparam logic [MAG_W-1:0] MAG_MAX   = 16'hFFFF;
   localparam logic [1:0]       RUN_END   = 2'd2;

endpackage

// ----- rtl/http_response_header_parser_unit.sv -----
// HTTP response status/header parser with body pass-through, one byte per beat.
// Depends on hrhp_pkg and http_response_header_parser_unit_macros.svh.
//
//   channel | ports                  | direction | content
//   --------+------------------------+-----------+-------------------------------
//   req     | req_valid/ready        | in        | one received response byte
//   rsp     | rsp_valid/ready        | out       | body flags, status, body length
//   csr     | csr_wr_en/csr_wr_data  | in        | body_capacity, write only
//
// The parser state and the result register
// update together at the accepting edge, and the result shows the next cycle.
// One request beat is accepted every cycle while the result register is empty
// or being drained, so the sustained rate is one byte per clock.
// A stalled rsp side holds the result and stops req after one beat.
// Reset is synchronous: state clears and body_capacity returns to 1500.
`include "http_response_header_parser_unit_macros.svh"

module http_response_header_parser_unit #(
   parameter int STATUS_LINE_MAX = 63,
   parameter int BODY_COUNT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hrhp_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_body_valid,
   output logic [hrhp_pkg::BYTE_W-1:0]        rsp_body_byte,
   output logic                               rsp_body_dropped,
   output logic                               rsp_header_done,
   output logic                               rsp_status_known,
   output logic signed [hrhp_pkg::CODE_W-1:0] rsp_status_code,
   output logic [hrhp_pkg::LEN_W-1:0]         rsp_body_length,
   input  logic                               csr_wr_en,
   input  logic [hrhp_pkg::CAP_W-1:0]         csr_wr_data
);

   localparam int CAPT_W = $clog2(STATUS_LINE_MAX + 1);
   // compare width for kept_count + 1 against the 17-bit capacity
   localparam int CMP_W  = (BODY_COUNT_BITS + 1 > hrhp_pkg::CAP_W) ?
                           BODY_COUNT_BITS + 1 : hrhp_pkg::CAP_W;
   localparam int PROD_W = hrhp_pkg::MAG_W + 4;

   // configuration
   logic [hrhp_pkg::CAP_W-1:0] capacity_ff;

   // parser state
   logic                       in_body_ff,  in_body_in;
   logic [1:0]                 nl_run_ff,   nl_run_in;
   logic [CAPT_W-1:0]          captured_ff, captured_in;
   logic                       space_ff,    space_in;
   logic                       line_nul_ff, line_nul_in;
   hrhp_pkg::phase_type        phase_ff,    phase_in;
   logic                       neg_ff,      neg_in;
   logic [hrhp_pkg::MAG_W-1:0] mag_ff,      mag_in;
   logic                       fixed_ff,    fixed_in;
   logic [BODY_COUNT_BITS-1:0] kept_ff,     kept_in;

   // result register
   logic                       out_valid_ff;
   logic                       out_bvalid_ff, out_bvalid_in;
   hrhp_pkg::byte_type         out_byte_ff,   out_byte_in;
   logic                       out_drop_ff,   out_drop_in;
   logic [hrhp_pkg::CODE_W-1:0] out_code_ff,  out_code_in;

   logic                       accept;
   hrhp_pkg::byte_type         c;
   logic                       capture;
   logic                       is_digit;
   logic [PROD_W-1:0]          mag_next;
   logic [1:0]                 run_inc;
   logic [CMP_W-1:0]           kept_plus1;
   logic                       room;

   // Take a new beat whenever the result slot is free or draining.
   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign c         = req_rx_byte;

   assign is_digit  = (c >= hrhp_pkg::CHAR_ZERO) && (c <= hrhp_pkg::CHAR_NINE);
   // mag * 10 + digit; mag never exceeds 65535 so this fits in 20 bits
   assign mag_next  = {mag_ff, 3'b000} + {2'b00, mag_ff, 1'b0}
                    + PROD_W'(c - hrhp_pkg::CHAR_ZERO);
   assign capture   = !fixed_ff && (c != hrhp_pkg::CHAR_CR) && (c != hrhp_pkg::CHAR_LF)
                    && (captured_ff < CAPT_W'(STATUS_LINE_MAX));
   assign run_inc   = (nl_run_ff < hrhp_pkg::RUN_END) ? nl_run_ff + 2'd1 : nl_run_ff;
   assign kept_plus1 = CMP_W'(kept_ff) + CMP_W'(1);
   assign room      = (kept_plus1 < CMP_W'(capacity_ff)) && !(&kept_ff);

   always_comb begin
      in_body_in    = in_body_ff;
      nl_run_in     = nl_run_ff;
      captured_in   = captured_ff;
      space_in      = space_ff;
      line_nul_in   = line_nul_ff;
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      fixed_in      = fixed_ff;
      kept_in       = kept_ff;
      out_bvalid_in = 1'b0;
      out_byte_in   = '0;
      out_drop_in   = 1'b0;

      if (!in_body_ff) begin
         // Header byte: capture into the status line, then track line ends.
         if (capture) begin
            captured_in = captured_ff + CAPT_W'(1);
            if (space_ff) begin
               if (phase_ff != hrhp_pkg::PH_DONE) begin
                  if (is_digit) begin
                     mag_in   = (mag_next > PROD_W'(hrhp_pkg::MAG_MAX)) ?
                                hrhp_pkg::MAG_MAX : mag_next[hrhp_pkg::MAG_W-1:0];
                     phase_in = hrhp_pkg::PH_DIGITS;
                  end else if (phase_ff == hrhp_pkg::PH_SKIP &&
                               (c == hrhp_pkg::CHAR_SPACE || c == hrhp_pkg::CHAR_TAB ||
                                c == hrhp_pkg::CHAR_VT    || c == hrhp_pkg::CHAR_FF)) begin
                     phase_in = phase_ff;
                  end else if (phase_ff == hrhp_pkg::PH_SKIP &&
                               (c == hrhp_pkg::CHAR_PLUS || c == hrhp_pkg::CHAR_MINUS)) begin
                     neg_in   = (c == hrhp_pkg::CHAR_MINUS);
                     phase_in = hrhp_pkg::PH_SIGN;
                  end else begin
                     phase_in = hrhp_pkg::PH_DONE;
                  end
               end
            end else if (c == hrhp_pkg::CHAR_NUL) begin
               line_nul_in = 1'b1;
            end else if (c == hrhp_pkg::CHAR_SPACE && !line_nul_ff) begin
               space_in = 1'b1;
            end
         end
         if (c == hrhp_pkg::CHAR_LF) begin
            if (space_ff) begin
               fixed_in = 1'b1;
            end
            nl_run_in = run_inc;
            if (run_inc >= hrhp_pkg::RUN_END) begin
               in_body_in = 1'b1;
            end
         end else if (c != hrhp_pkg::CHAR_CR) begin
            nl_run_in = 2'd0;
         end
      end else if (room) begin
         // Keep the body byte.
         kept_in       = kept_ff + BODY_COUNT_BITS'(1);
         out_bvalid_in = 1'b1;
         out_byte_in   = c;
      end else begin
         out_drop_in = 1'b1;
      end

      if (fixed_in) begin
         out_code_in = neg_in ? (hrhp_pkg::CODE_W'(0) - hrhp_pkg::CODE_W'(mag_in))
                              : hrhp_pkg::CODE_W'(mag_in);
      end else begin
         out_code_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= hrhp_pkg::CAP_RESET;
         in_body_ff   <= 1'b0;
         nl_run_ff    <= 2'd0;
         captured_ff  <= '0;
         space_ff     <= 1'b0;
         line_nul_ff  <= 1'b0;
         phase_ff     <= hrhp_pkg::PH_SKIP;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         fixed_ff     <= 1'b0;
         kept_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (accept) begin
            // Advance the parser and load the result in the same edge.
            in_body_ff   <= in_body_in;
            nl_run_ff    <= nl_run_in;
            captured_ff  <= captured_in;
            space_ff     <= space_in;
            line_nul_ff  <= line_nul_in;
            phase_ff     <= phase_in;
            neg_ff       <= neg_in;
            mag_ff       <= mag_in;
            fixed_ff     <= fixed_in;
            kept_ff      <= kept_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            // Drop the slot once the beat has been taken.
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload of the result register: no reset, loaded on accept only.
   always_ff @(posedge clock) begin
      if (accept) begin
         out_bvalid_ff <= out_bvalid_in;
         out_byte_ff   <= out_byte_in;
         out_drop_ff   <= out_drop_in;
         out_code_ff   <= out_code_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_body_valid   = out_bvalid_ff;
   assign rsp_body_byte    = out_byte_ff;
   assign rsp_body_dropped = out_drop_ff;
   assign rsp_header_done  = in_body_ff;
   assign rsp_status_known = fixed_ff;
   assign rsp_status_code  = out_code_ff;
   assign rsp_body_length  = hrhp_pkg::LEN_W'(kept_ff);

   // Checks on the parser's own state.
   `HRHP_ASSERT_NEXT(a_body_sticky, clock, reset, in_body_ff, in_body_ff)
   `HRHP_ASSERT_NEXT(a_status_frozen, clock, reset, fixed_ff,
                     fixed_ff && $stable(mag_ff) && $stable(neg_ff))
   `HRHP_ASSERT_SAME(a_kept_in_body, clock, reset, out_valid_ff && out_bvalid_ff,
                     in_body_ff && !out_drop_ff)
   `HRHP_ASSERT_SAME(a_capture_bound, clock, reset, 1'b1,
                     captured_ff <= CAPT_W'(STATUS_LINE_MAX))

endmodule
